@@ design/pfc_pkg.sv @@
// Shared types, register indexes and sizes for the PID force controller.
`default_nettype none

package pfc_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_GAIN_P    = 3'd0;
    localparam logic [2:0] REG_GAIN_I    = 3'd1;
    localparam logic [2:0] REG_GAIN_D    = 3'd2;
    localparam logic [2:0] REG_SETPOINT  = 3'd3;
    localparam logic [2:0] REG_FORCE_CAP = 3'd4;
    localparam logic [2:0] REG_DRIVE_MIN = 3'd5;
    localparam logic [2:0] REG_DRIVE_MAX = 3'd6;

    // Register reset values
    localparam logic [15:0] GAIN_P_RST     = 16'd512;
    localparam logic [15:0] GAIN_I_RST     = 16'd128;
    localparam logic [15:0] GAIN_D_RST     = 16'd26;
    localparam logic [30:0] FORCE_CAP_RST  = 31'd32768000;
    localparam logic [22:0] DRIVE_MAX_RST  = 23'd6553600;

    // Input commands
    localparam logic CMD_PROCESS = 1'b0;
    localparam logic CMD_CLEAR   = 1'b1;

    // Shared multiplier operand select
    typedef logic [1:0] t_msel;
    localparam t_msel MSEL_P = 2'd0;
    localparam t_msel MSEL_I = 2'd1;
    localparam t_msel MSEL_D = 2'd2;

    // Integral limit divider: dividend is drive_max * 256
    localparam int DIV_BITS = 31;
    localparam int DIV_CNT_W = $clog2(DIV_BITS);

    // Controller to datapath commands
    typedef struct packed {
        logic  load;      // latch error and saturated sum, start divider
        logic  clear;     // zero integral and last error
        logic  div_step;  // one quotient bit
        logic  clamp;     // apply integral clamp, form derivative
        logic  mul_en;    // register one product
        t_msel mul_sel;
        logic  acc_first; // load accumulator with product
        logic  acc_add;   // add product into accumulator
        logic  out_load;  // register clipped drive
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic div_last;
        logic gain_i_zero;
    } t_status;

endpackage

`default_nettype wire

@@ design/pfc_ctrl.sv @@
// Sequencer for the PID force controller: handshakes and step order.
`default_nettype none

module pfc_ctrl
    import pfc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_cmd,
    input  wire logic    i_out_ready,
    input  wire t_status i_status,
    output logic         o_in_ready,
    output logic         o_out_valid,
    output t_cmd         o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_CLAMP = 3'd2;
    localparam logic [2:0] ST_MUL_P = 3'd3;
    localparam logic [2:0] ST_MUL_I = 3'd4;
    localparam logic [2:0] ST_MUL_D = 3'd5;
    localparam logic [2:0] ST_ACC   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       in_beat;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_beat     = i_in_valid && o_in_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    if (i_cmd == CMD_CLEAR) begin
                        o_cmd.clear = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state = i_status.gain_i_zero ? ST_CLAMP : ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) n_state = ST_CLAMP;
            end
            ST_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state = ST_MUL_P;
            end
            ST_MUL_P: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MSEL_P;
                n_state = ST_MUL_I;
            end
            ST_MUL_I: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_sel   = MSEL_I;
                o_cmd.acc_first = 1'b1;
                n_state = ST_MUL_D;
            end
            ST_MUL_D: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MSEL_D;
                o_cmd.acc_add = 1'b1;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc_add = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                // wait here while the previous result is still held
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load)                  n_out_valid = 1'b1;
        else if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

@@ design/pfc_datapath.sv @@
// Datapath: config registers, error/integral state, serial divider, MAC, clip.
`default_nettype none

module pfc_datapath
    import pfc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_status          o_status,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic [31:0] i_measured_force,
    output logic [22:0]      o_drive
);

    // Configuration registers
    logic [15:0] r_gain_p, r_gain_i, r_gain_d;
    logic [31:0] r_setpoint;
    logic [30:0] r_force_cap;
    logic [22:0] r_drive_min, r_drive_max;

    // Loop state and work registers
    logic signed [47:0] r_sum;      // integral
    logic signed [32:0] r_prev;     // last error
    logic signed [32:0] r_err;
    logic signed [47:0] r_sum_new;  // saturated, not yet clamped
    logic signed [33:0] r_deriv;
    logic [15:0]        r_rem;
    logic [30:0]        r_quo;      // dividend in, limit out
    logic [DIV_CNT_W-1:0] r_cnt;
    logic signed [50:0] r_prod;
    logic signed [51:0] r_total;
    logic [22:0]        r_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= GAIN_P_RST;
            r_gain_i    <= GAIN_I_RST;
            r_gain_d    <= GAIN_D_RST;
            r_setpoint  <= '0;
            r_force_cap <= FORCE_CAP_RST;
            r_drive_min <= '0;
            r_drive_max <= DRIVE_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_GAIN_P:    r_gain_p    <= i_cfg_data[15:0];
                REG_GAIN_I:    r_gain_i    <= i_cfg_data[15:0];
                REG_GAIN_D:    r_gain_d    <= i_cfg_data[15:0];
                REG_SETPOINT:  r_setpoint  <= i_cfg_data;
                REG_FORCE_CAP: r_force_cap <= i_cfg_data[30:0];
                REG_DRIVE_MIN: r_drive_min <= i_cfg_data[22:0];
                REG_DRIVE_MAX: r_drive_max <= i_cfg_data[22:0];
                default: ;
            endcase
        end
    end

    // Error against the limited target, and saturated integral
    logic signed [32:0] tgt, err;
    logic signed [48:0] sum_raw;
    logic signed [47:0] sum_sat;
    localparam logic signed [47:0] SUM_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] SUM_MIN = {1'b1, {47{1'b0}}};

    always_comb begin
        if ($signed(r_setpoint) < $signed({1'b0, r_force_cap}))
            tgt = {r_setpoint[31], r_setpoint};
        else
            tgt = {2'b00, r_force_cap};
        err = tgt - {i_measured_force[31], i_measured_force};
        sum_raw = {r_sum[47], r_sum} + {{16{err[32]}}, err};
        if (sum_raw > $signed({SUM_MAX[47], SUM_MAX}))      sum_sat = SUM_MAX;
        else if (sum_raw < $signed({SUM_MIN[47], SUM_MIN})) sum_sat = SUM_MIN;
        else                                                sum_sat = sum_raw[47:0];
    end

    // Restoring divider step: limit = drive_max * 256 / gain_i
    logic [16:0] rem_sh, rem_sub;
    logic        q_bit;
    assign rem_sh  = {r_rem, r_quo[DIV_BITS-1]};
    assign rem_sub = rem_sh - {1'b0, r_gain_i};
    assign q_bit   = (rem_sh >= {1'b0, r_gain_i});

    assign o_status.div_last    = (r_cnt == DIV_CNT_W'(DIV_BITS - 1));
    assign o_status.gain_i_zero = (r_gain_i == '0);

    // Integral clamp against the divider result
    logic signed [47:0] lim_pos, lim_neg, sum_clamped;
    always_comb begin
        lim_pos = $signed({17'b0, r_quo});
        lim_neg = -lim_pos;
        sum_clamped = r_sum_new;
        if (!o_status.gain_i_zero) begin
            if (sum_clamped > lim_pos) sum_clamped = lim_pos;
            if (sum_clamped < lim_neg) sum_clamped = lim_neg;
        end
    end

    // Shared multiplier; integral fits 34 bits once clamped (zero gain gives 0)
    logic signed [16:0] mul_a;
    logic signed [33:0] mul_b;
    always_comb begin
        case (i_cmd.mul_sel)
            MSEL_P: begin
                mul_a = $signed({1'b0, r_gain_p});
                mul_b = {r_err[32], r_err};
            end
            MSEL_I: begin
                mul_a = $signed({1'b0, r_gain_i});
                mul_b = r_sum[33:0];
            end
            MSEL_D: begin
                mul_a = $signed({1'b0, r_gain_d});
                mul_b = r_deriv;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Drive clip: upper bound first, lower bound wins
    logic signed [51:0] hi, lo;
    logic               gt, lt;
    logic [22:0]        drv;
    always_comb begin
        hi = $signed({21'b0, r_drive_max, 8'b0});
        lo = $signed({21'b0, r_drive_min, 8'b0});
        gt = (r_total > hi);
        lt = (r_total < lo);
        if (gt)      drv = r_drive_max;
        else if (lt) drv = r_drive_min;
        else         drv = r_total[30:8];
        if (gt && (r_drive_max < r_drive_min)) drv = r_drive_min;
    end

    // Loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_prev <= '0;
        end else if (i_cmd.clear) begin
            r_sum  <= '0;
            r_prev <= '0;
        end else if (i_cmd.clamp) begin
            r_sum  <= sum_clamped;
            r_prev <= r_err;
        end
    end

    // Work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_err     <= err;
            r_sum_new <= sum_sat;
            r_quo     <= {r_drive_max, 8'b0};
            r_rem     <= '0;
            r_cnt     <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? rem_sub[15:0] : rem_sh[15:0];
            r_quo <= {r_quo[DIV_BITS-2:0], q_bit};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.clamp) r_deriv <= {r_err[32], r_err} - {r_prev[32], r_prev};
        if (i_cmd.mul_en) r_prod <= mul_a * mul_b;
        if (i_cmd.acc_first)    r_total <= {r_prod[50], r_prod};
        else if (i_cmd.acc_add) r_total <= r_total + {r_prod[50], r_prod};
        if (i_cmd.out_load) r_drive <= drv;
    end

    assign o_drive = r_drive;

endmodule

`default_nettype wire

@@ design/pid_force_controller.sv @@
// Top level of the PID force controller.
//
// Use: configuration writes go over the cfg channel (index 0..6: gain_p,
// gain_i, gain_d, setpoint, force cap, drive_min, drive_max) while the
// block is idle; cfg ready is always high. Each input beat carries a command
// and a force sample. A process beat yields one drive beat; a clear beat zeroes
// the integral and the last error and yields nothing.
// Flow: after a process beat is accepted, the 31-step serial divider forms
// the integral limit, then the clamp, the P, I and D products, the final add
// and the output load follow before the input is ready again and the result
// is held on the output; with gain_i at zero the divider is skipped. One
// sample is worked on at a time: no new process beat is taken before that.
// The drive sits in an output register: the next sample is taken while a
// result still waits. If the receiver stalls, the following result waits
// in its last step until the register is free.
// Reset (synchronous, active low) loads the register defaults and zeroes the
// integral and the last error; no result is pending after reset.
`default_nettype none

module pid_force_controller
    import pfc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_cmd,
    input  wire logic [31:0] i_measured_force,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [22:0]      o_drive,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    pfc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cmd       (i_cmd),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    pfc_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_measured_force (i_measured_force),
        .o_drive          (o_drive)
    );

endmodule

`default_nettype wire

@@ design/pfc_checker.sv @@
// Port-level checks for the PID force controller, bound to the top level.
`default_nettype none

module pfc_checker
    import pfc_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        i_cmd,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [22:0] o_drive
);

    // A waiting result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // A waiting result keeps its value
    a_drive_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_drive))
        else $error("drive changed while stalled");

    // A process beat makes the block busy
    a_busy_after_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_cmd == CMD_PROCESS) |=> !o_in_ready)
        else $error("input taken while a sample is in work");

    // A new result appears just as the block returns to idle
    a_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result raised while still busy");

endmodule

bind pid_force_controller pfc_checker u_pfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_cmd       (i_cmd),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_drive     (o_drive)
);

`default_nettype wire
